>>> rtl/rcc_pkg.sv
// ----------------------------------------------------------------------------
// rcc_pkg
// Types, command codes and helper functions shared by the calendar clock.
// ----------------------------------------------------------------------------
package rcc_pkg;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_SET_TIME = 2'd1,
        CMD_SET_DATE = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  set_hour;
        logic [5:0]  set_minute;
        logic [5:0]  set_second;
        logic [4:0]  set_day;
        logic [3:0]  set_month;
        logic [15:0] set_year;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  hour_tens;
        logic [3:0]  hour_ones;
        logic [2:0]  minute_tens;
        logic [3:0]  minute_ones;
        logic [2:0]  second_tens;
        logic [3:0]  second_ones;
        logic [4:0]  day_out;
        logic [3:0]  month_out;
        logic [15:0] year_out;
        logic        date_rejected;
    } t_out_item;

    // time of day held as bcd digits
    typedef struct packed {
        logic [1:0] h_t;
        logic [3:0] h_o;
        logic [2:0] m_t;
        logic [3:0] m_o;
        logic [2:0] s_t;
        logic [3:0] s_o;
    } t_time;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
    } t_date;

    typedef struct packed {
        logic [2:0] tens;
        logic [3:0] ones;
    } t_bcd;

    localparam t_time TIME_RESET = '{h_t: 2'd1, h_o: 4'd4, m_t: 3'd1, m_o: 4'd2,
                                     s_t: 3'd2, s_o: 4'd0};
    localparam t_date DATE_RESET = '{day: 5'd3, month: 4'd9, year: 16'd2019};

    localparam logic [3:0]  DIGIT_MAX   = 4'd9;
    localparam logic [2:0]  TENS_MAX    = 3'd5;
    localparam logic [1:0]  HOUR_T_MAX  = 2'd2;
    localparam logic [3:0]  HOUR_O_LAST = 4'd3;
    localparam logic [4:0]  HOUR_MAX    = 5'd23;
    localparam logic [5:0]  MIN_SEC_MAX = 6'd59;
    localparam logic [3:0]  MONTH_LAST  = 4'd12;
    localparam logic [13:0] DIV10_MUL   = 14'd205;
    // multiplicative inverse of 25 modulo 2^16 and the largest multiple index
    localparam logic [15:0] INV25       = 16'h5C29;
    localparam logic [15:0] DIV25_MAX   = 16'd2621;

    // binary 0..63 to two bcd digits, tens by reciprocal multiply
    function automatic t_bcd to_bcd(input logic [5:0] v);
        logic [13:0] prod;
        logic [2:0]  tens;
        logic [6:0]  tens_x10;
        t_bcd        r;
        prod     = 14'(v) * DIV10_MUL;
        tens     = prod[13:11];
        tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
        r.tens   = tens;
        r.ones   = 4'(7'(v) - tens_x10);
        return r;
    endfunction

    function automatic logic is_leap(input logic [15:0] y);
        logic [15:0] p;
        logic        div25;
        p     = 16'(y * INV25);
        div25 = (p <= DIV25_MAX);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:2] == 2'b00));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

>>> rtl/rcc_if.sv
// ----------------------------------------------------------------------------
// rcc interfaces
// Valid/ready channels for commands into and results out of the clock.
// ----------------------------------------------------------------------------
interface rcc_cmd_if import rcc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rcc_res_if import rcc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/rcc_date_unit.sv
// ----------------------------------------------------------------------------
// rcc_date_unit
// Next-date logic: day advance by gregorian month length and set-date check.
// ----------------------------------------------------------------------------
module rcc_date_unit import rcc_pkg::*; (
    input  t_date i_date,
    input  logic  i_advance,
    input  logic  i_set,
    input  t_date i_set_date,
    output t_date o_date,
    output logic  o_rejected
);

    logic [15:0] year_sel;
    logic        leap;
    logic [3:0]  month_sel;
    logic [4:0]  len;
    logic        set_ok;

    // one leap test shared by the set check and the day advance
    assign year_sel  = i_set ? i_set_date.year  : i_date.year;
    assign month_sel = i_set ? i_set_date.month : i_date.month;
    assign leap      = is_leap(year_sel);
    assign len       = month_len(month_sel, leap);
    assign set_ok    = (i_set_date.day != 5'd0) && (i_set_date.day <= len);

    always_comb begin
        o_date     = i_date;
        o_rejected = 1'b0;
        if (i_set) begin
            if (set_ok) begin
                o_date = i_set_date;
            end else begin
                o_rejected = 1'b1;
            end
        end else if (i_advance) begin
            if (i_date.day < len) begin
                o_date.day = i_date.day + 5'd1;
            end else begin
                o_date.day = 5'd1;
                if (i_date.month >= MONTH_LAST) begin
                    o_date.month = 4'd1;
                    o_date.year  = i_date.year + 16'd1;
                end else begin
                    o_date.month = i_date.month + 4'd1;
                end
            end
        end
    end

endmodule

>>> rtl/rtc_calendar_clock_top.sv
// ----------------------------------------------------------------------------
// rtc_calendar_clock_top
// Calendar clock: tick, set time, set date and no-op commands, one result each.
// ----------------------------------------------------------------------------
// channel    direction  payload                               handshake
// i_cmd_if   in         cmd, set time and set date fields      valid/ready
// o_res_if   out        bcd time digits, date, reject flag     valid/ready
//
// one transaction per cycle sustained while results are taken; a taken command
// passes the input register, then the state and result register, to be offered.
// the time/date update is one pass of bcd counters and the date unit.
// synchronous reset loads 14:12:20 on 3 sep 2019 and empties both stages.
// a stalled result holds the pipe; the input stage still takes one more.
// ----------------------------------------------------------------------------
module rtc_calendar_clock_top import rcc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rcc_cmd_if.sink   i_cmd_if,
    rcc_res_if.source o_res_if
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_time     r_time;
    t_date     r_date;

    t_time     n_time;
    t_date     n_date;
    t_date     set_date;
    logic      rejected;
    logic      day_wrap;
    logic      out_free;
    logic      advance;
    t_bcd      hr_bcd;
    t_bcd      mi_bcd;
    t_bcd      se_bcd;
    logic      time_ok;

    assign out_free        = !r_out_valid || o_res_if.ready;
    assign advance         = r_in_valid && out_free;
    assign i_cmd_if.ready  = !r_in_valid || out_free;
    assign o_res_if.valid  = r_out_valid;
    assign o_res_if.data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd_if.ready) begin
            r_in_valid <= i_cmd_if.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_if.valid && i_cmd_if.ready) begin
            r_in <= i_cmd_if.data;
        end
    end

    // time of day update
    assign hr_bcd   = to_bcd({1'b0, r_in.set_hour});
    assign mi_bcd   = to_bcd(r_in.set_minute);
    assign se_bcd   = to_bcd(r_in.set_second);
    assign time_ok  = (r_in.set_hour <= HOUR_MAX) && (r_in.set_minute <= MIN_SEC_MAX)
                      && (r_in.set_second <= MIN_SEC_MAX);
    assign day_wrap = (r_time.h_t == HOUR_T_MAX) && (r_time.h_o == HOUR_O_LAST)
                      && (r_time.m_t == TENS_MAX) && (r_time.m_o == DIGIT_MAX)
                      && (r_time.s_t == TENS_MAX) && (r_time.s_o == DIGIT_MAX);

    always_comb begin
        n_time = r_time;
        case (r_in.cmd)
            CMD_TICK: begin
                if (r_time.s_o != DIGIT_MAX) begin
                    n_time.s_o = r_time.s_o + 4'd1;
                end else begin
                    n_time.s_o = 4'd0;
                    if (r_time.s_t != TENS_MAX) begin
                        n_time.s_t = r_time.s_t + 3'd1;
                    end else begin
                        n_time.s_t = 3'd0;
                        if (r_time.m_o != DIGIT_MAX) begin
                            n_time.m_o = r_time.m_o + 4'd1;
                        end else begin
                            n_time.m_o = 4'd0;
                            if (r_time.m_t != TENS_MAX) begin
                                n_time.m_t = r_time.m_t + 3'd1;
                            end else begin
                                n_time.m_t = 3'd0;
                                if (r_time.h_t == HOUR_T_MAX && r_time.h_o == HOUR_O_LAST) begin
                                    n_time.h_t = 2'd0;
                                    n_time.h_o = 4'd0;
                                end else if (r_time.h_o == DIGIT_MAX) begin
                                    n_time.h_o = 4'd0;
                                    n_time.h_t = r_time.h_t + 2'd1;
                                end else begin
                                    n_time.h_o = r_time.h_o + 4'd1;
                                end
                            end
                        end
                    end
                end
            end
            CMD_SET_TIME: begin
                if (time_ok) begin
                    n_time.h_t = hr_bcd.tens[1:0];
                    n_time.h_o = hr_bcd.ones;
                    n_time.m_t = mi_bcd.tens;
                    n_time.m_o = mi_bcd.ones;
                    n_time.s_t = se_bcd.tens;
                    n_time.s_o = se_bcd.ones;
                end
            end
            default: begin
                n_time = r_time;
            end
        endcase
    end

    assign set_date = '{day: r_in.set_day, month: r_in.set_month, year: r_in.set_year};

    rcc_date_unit u_date (
        .i_date     (r_date),
        .i_advance  ((r_in.cmd == CMD_TICK) && day_wrap),
        .i_set      (r_in.cmd == CMD_SET_DATE),
        .i_set_date (set_date),
        .o_date     (n_date),
        .o_rejected (rejected)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_time      <= TIME_RESET;
            r_date      <= DATE_RESET;
        end else begin
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_time <= n_time;
                r_date <= n_date;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.hour_tens     <= n_time.h_t;
            r_out.hour_ones     <= n_time.h_o;
            r_out.minute_tens   <= n_time.m_t;
            r_out.minute_ones   <= n_time.m_o;
            r_out.second_tens   <= n_time.s_t;
            r_out.second_ones   <= n_time.s_o;
            r_out.day_out       <= n_date.day;
            r_out.month_out     <= n_date.month;
            r_out.year_out      <= n_date.year;
            r_out.date_rejected <= rejected;
        end
    end

endmodule

>>> rtl/rcc_checker.sv
// ----------------------------------------------------------------------------
// rcc_checker
// Port-level checks on the calendar clock result channel.
// ----------------------------------------------------------------------------
module rcc_checker import rcc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    // sync reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.hour_tens <= 2'd2) && (i_out_data.hour_ones <= 4'd9)
            && !(i_out_data.hour_tens == 2'd2 && i_out_data.hour_ones > 4'd3)
            && (i_out_data.minute_tens <= 3'd5) && (i_out_data.minute_ones <= 4'd9)
            && (i_out_data.second_tens <= 3'd5) && (i_out_data.second_ones <= 4'd9))
        else $error("time digits out of range");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.day_out != 5'd0) && (i_out_data.month_out != 4'd0)
            && (i_out_data.month_out <= 4'd12))
        else $error("date out of range");

endmodule

bind rtc_calendar_clock_top rcc_checker u_rcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res_if.valid),
    .i_out_ready (o_res_if.ready),
    .i_out_data  (o_res_if.data)
);

>>> bench/tb_rtc_calendar_clock_top.sv
// ----------------------------------------------------------------------------
// tb_rtc_calendar_clock_top
// Self-checking bench for the calendar clock. A short table of directed
// commands (field extremes, rejected dates, ignored times, year wrap) is
// followed by random command streams built around midnight and month-end
// rollovers. Results are checked against pinned readings or a calendar model kept here.
// ----------------------------------------------------------------------------
module tb_rtc_calendar_clock_top;
    import rcc_pkg::*;

    typedef struct packed {
        t_in_item  item;
        logic      pin;
        t_out_item want;
    } t_cal_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rcc_cmd_if cmd_if ();
    rcc_res_if res_if ();

    rtc_calendar_clock_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_if (cmd_if),
        .o_res_if (res_if)
    );

    always #2 i_clk = ~i_clk;

    // calendar model state
    logic [16:0] cal_secs;
    logic [4:0]  cal_day;
    logic [3:0]  cal_mon;
    logic [15:0] cal_year;

    t_cal_row  cmd_queue[$];
    t_cal_row  dir_tab[$];
    t_out_item due_readings[$];
    t_cal_row  cur_row;

    int errors = 0;
    int rows_queued = 0;
    int cmds_taken = 0;
    int rejects_seen = 0;
    int day_rolls = 0;
    int gap_left = 0;
    int burst_left = 0;
    logic [15:0] stall_pat = 16'hFFFF;
    logic [3:0]  stall_idx = 4'd0;

    function automatic bit leap_year(input logic [15:0] y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic [15:0] y);
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    return 5'd30;
            4'd2:                                       return leap_year(y) ? 5'd29 : 5'd28;
            default:                                    return 5'd0;
        endcase
    endfunction

    function automatic void roll_day();
        day_rolls++;
        if (cal_day < days_in(cal_mon, cal_year)) begin
            cal_day = cal_day + 5'd1;
        end else begin
            cal_day = 5'd1;
            if (cal_mon >= MONTH_LAST) begin
                cal_mon  = 4'd1;
                cal_year = cal_year + 16'd1;
            end else begin
                cal_mon = cal_mon + 4'd1;
            end
        end
    endfunction

    function automatic t_out_item advance_calendar(input t_in_item it);
        t_out_item   r;
        int unsigned rest, hh, mm, ss;
        r = '0;
        case (it.cmd)
            CMD_TICK: begin
                if (cal_secs >= 17'd86399) begin
                    cal_secs = '0;
                    roll_day();
                end else begin
                    cal_secs = cal_secs + 17'd1;
                end
            end
            CMD_SET_TIME: begin
                if (it.set_hour <= 5'd23 && it.set_minute <= 6'd59 && it.set_second <= 6'd59)
                    cal_secs = 17'(it.set_hour * 3600 + it.set_minute * 60 + it.set_second);
            end
            CMD_SET_DATE: begin
                if (it.set_day == 5'd0 || it.set_day > days_in(it.set_month, it.set_year)) begin
                    r.date_rejected = 1'b1;
                end else begin
                    cal_day  = it.set_day;
                    cal_mon  = it.set_month;
                    cal_year = it.set_year;
                end
            end
            default: ;
        endcase
        rest          = cal_secs % 86400;
        hh            = rest / 3600;
        mm            = (rest % 3600) / 60;
        ss            = rest % 60;
        r.hour_tens   = 2'(hh / 10);
        r.hour_ones   = 4'(hh % 10);
        r.minute_tens = 3'(mm / 10);
        r.minute_ones = 4'(mm % 10);
        r.second_tens = 3'(ss / 10);
        r.second_ones = 4'(ss % 10);
        r.day_out     = cal_day;
        r.month_out   = cal_mon;
        r.year_out    = cal_year;
        return r;
    endfunction

    // reading typed in by hand for the directed table
    function automatic t_out_item reading(input int hh, mm, ss, dd, mo, yy, input bit rej);
        t_out_item r;
        r.hour_tens     = 2'(hh / 10);
        r.hour_ones     = 4'(hh % 10);
        r.minute_tens   = 3'(mm / 10);
        r.minute_ones   = 4'(mm % 10);
        r.second_tens   = 3'(ss / 10);
        r.second_ones   = 4'(ss % 10);
        r.day_out       = 5'(dd);
        r.month_out     = 4'(mo);
        r.year_out      = 16'(yy);
        r.date_rejected = rej;
        return r;
    endfunction

    function automatic t_cal_row cmd_row(input t_cmd op, input int hh, mm, ss, dd, mo, yy);
        t_cal_row row;
        row                 = '0;
        row.item.cmd        = op;
        row.item.set_hour   = 5'(hh);
        row.item.set_minute = 6'(mm);
        row.item.set_second = 6'(ss);
        row.item.set_day    = 5'(dd);
        row.item.set_month  = 4'(mo);
        row.item.set_year   = 16'(yy);
        return row;
    endfunction

    function automatic t_cal_row pin(input t_cal_row row, input t_out_item want);
        t_cal_row r;
        r      = row;
        r.pin  = 1'b1;
        r.want = want;
        return r;
    endfunction

    // all fields random, then the command forced
    function automatic t_cal_row junk_row(input t_cmd op);
        t_cal_row    row;
        logic [63:0] bits;
        bits         = {$urandom, $urandom};
        row          = '0;
        row.item     = bits[$bits(t_in_item)-1:0];
        row.item.cmd = op;
        return row;
    endfunction

    function automatic logic [15:0] pick_year();
        case ($urandom_range(0, 6))
            0:       return 16'hFFFF;
            1:       return 16'(400 * $urandom_range(0, 163));
            2:       return 16'(100 * $urandom_range(0, 655));
            3:       return 16'(4 * $urandom_range(0, 16383));
            4:       return 16'($urandom_range(1990, 2110));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_row(input t_cal_row row);
        cmd_queue.push_back(row);
        rows_queued++;
    endtask

    task automatic queue_random_mix(input int n_rows);
        int          start, kind, len, k;
        logic [15:0] y;
        logic [3:0]  m;
        t_cal_row    row;
        start = rows_queued;
        while (rows_queued - start < n_rows) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                // valid date, mostly near month end, time just before midnight, then ticks
                y   = pick_year();
                m   = 4'($urandom_range(1, 12));
                len = days_in(m, y);
                row = junk_row(CMD_SET_DATE);
                row.item.set_year  = y;
                row.item.set_month = m;
                row.item.set_day   = ($urandom_range(0, 3) == 0) ?
                                     5'($urandom_range(1, len)) : 5'(len - $urandom_range(0, 1));
                add_row(row);
                row = junk_row(CMD_SET_TIME);
                row.item.set_hour   = 5'd23;
                row.item.set_minute = 6'd59;
                row.item.set_second = 6'($urandom_range(54, 59));
                add_row(row);
                k = $urandom_range(1, 8);
                repeat (k) add_row(junk_row(CMD_TICK));
            end else if (kind < 70) begin
                add_row(junk_row(CMD_SET_DATE));
            end else if (kind < 82) begin
                row = junk_row(CMD_SET_TIME);
                if ($urandom_range(0, 1) == 0) begin
                    row.item.set_hour   = 5'($urandom_range(0, 23));
                    row.item.set_minute = 6'($urandom_range(0, 59));
                    row.item.set_second = 6'($urandom_range(0, 59));
                end
                add_row(row);
            end else if (kind < 94) begin
                k = $urandom_range(1, 12);
                repeat (k) add_row(junk_row(CMD_TICK));
            end else begin
                add_row(junk_row(CMD_NONE));
            end
        end
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || cmd_if.valid || due_readings.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want, got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // command sender: bursts of random length with random gaps
    always @(posedge i_clk) begin : cmd_sender
        t_cal_row next_row;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_if.ready) begin
            if (gap_left != 0) begin
                gap_left     <= gap_left - 1;
                cmd_if.valid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
                next_row     = cmd_queue.pop_front();
                cmd_if.valid <= 1'b1;
                cmd_if.data  <= next_row.item;
                cur_row      <= next_row;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // result receiver: ready follows a 16-bit pattern, redrawn each lap
    always @(posedge i_clk) begin : res_receiver
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= stall_pat[stall_idx];
            stall_idx    <= stall_idx + 4'd1;
            if (stall_idx == 4'd15)
                stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end
    end

    always @(posedge i_clk) begin : reading_check
        t_out_item want;
        t_out_item got;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got = res_if.data;
                if (due_readings.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected, expected none, got %h",
                             $time, got);
                end else begin
                    want = due_readings.pop_front();
                    check_field("hour_tens", want.hour_tens, got.hour_tens);
                    check_field("hour_ones", want.hour_ones, got.hour_ones);
                    check_field("minute_tens", want.minute_tens, got.minute_tens);
                    check_field("minute_ones", want.minute_ones, got.minute_ones);
                    check_field("second_tens", want.second_tens, got.second_tens);
                    check_field("second_ones", want.second_ones, got.second_ones);
                    check_field("day_out", want.day_out, got.day_out);
                    check_field("month_out", want.month_out, got.month_out);
                    check_field("year_out", want.year_out, got.year_out);
                    check_field("date_rejected", want.date_rejected, got.date_rejected);
                end
            end
            if (cmd_if.valid && cmd_if.ready) begin
                want = advance_calendar(cur_row.item);
                if (cur_row.pin)
                    want = cur_row.want;
                if (want.date_rejected)
                    rejects_seen++;
                due_readings.push_back(want);
                cmds_taken++;
            end
        end
    end

    initial begin : main
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        res_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        cal_secs     = 17'd51140;
        cal_day      = 5'd3;
        cal_mon      = 4'd9;
        cal_year     = 16'd2019;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        dir_tab.push_back(pin(cmd_row(CMD_TICK, 0, 0, 0, 0, 0, 0),
                              reading(14, 12, 21, 3, 9, 2019, 0)));
        dir_tab.push_back(pin(cmd_row(CMD_NONE, 31, 63, 63, 31, 15, 65535),
                              reading(14, 12, 21, 3, 9, 2019, 0)));
        dir_tab.push_back(pin(cmd_row(CMD_SET_TIME, 23, 59, 59, 0, 0, 0),
                              reading(23, 59, 59, 3, 9, 2019, 0)));
        dir_tab.push_back(pin(cmd_row(CMD_SET_DATE, 0, 0, 0, 31, 12, 65535),
                              reading(23, 59, 59, 31, 12, 65535, 0)));
        // last second of the last representable year wraps to year zero
        dir_tab.push_back(pin(cmd_row(CMD_TICK, 0, 0, 0, 0, 0, 0),
                              reading(0, 0, 0, 1, 1, 0, 0)));
        dir_tab.push_back(pin(cmd_row(CMD_SET_DATE, 0, 0, 0, 29, 2, 2019),
                              reading(0, 0, 0, 1, 1, 0, 1)));
        dir_tab.push_back(pin(cmd_row(CMD_SET_DATE, 0, 0, 0, 30, 2, 2000),
                              reading(0, 0, 0, 1, 1, 0, 1)));
        dir_tab.push_back(pin(cmd_row(CMD_SET_DATE, 0, 0, 0, 31, 4, 2020),
                              reading(0, 0, 0, 1, 1, 0, 1)));
        dir_tab.push_back(pin(cmd_row(CMD_SET_DATE, 0, 0, 0, 31, 11, 2020),
                              reading(0, 0, 0, 1, 1, 0, 1)));
        dir_tab.push_back(pin(cmd_row(CMD_SET_DATE, 0, 0, 0, 0, 5, 2020),
                              reading(0, 0, 0, 1, 1, 0, 1)));
        dir_tab.push_back(pin(cmd_row(CMD_SET_DATE, 0, 0, 0, 15, 0, 2020),
                              reading(0, 0, 0, 1, 1, 0, 1)));
        dir_tab.push_back(pin(cmd_row(CMD_SET_DATE, 0, 0, 0, 15, 13, 2020),
                              reading(0, 0, 0, 1, 1, 0, 1)));
        dir_tab.push_back(pin(cmd_row(CMD_SET_DATE, 31, 63, 63, 31, 15, 65535),
                              reading(0, 0, 0, 1, 1, 0, 1)));
        dir_tab.push_back(pin(cmd_row(CMD_SET_DATE, 0, 0, 0, 29, 2, 1900),
                              reading(0, 0, 0, 1, 1, 0, 1)));
        // out-of-range times leave the clock alone and are not flagged
        dir_tab.push_back(pin(cmd_row(CMD_SET_TIME, 24, 0, 0, 0, 0, 0),
                              reading(0, 0, 0, 1, 1, 0, 0)));
        dir_tab.push_back(pin(cmd_row(CMD_SET_TIME, 31, 63, 63, 0, 0, 0),
                              reading(0, 0, 0, 1, 1, 0, 0)));
        dir_tab.push_back(pin(cmd_row(CMD_SET_TIME, 12, 60, 0, 0, 0, 0),
                              reading(0, 0, 0, 1, 1, 0, 0)));
        dir_tab.push_back(pin(cmd_row(CMD_SET_DATE, 0, 0, 0, 29, 2, 0),
                              reading(0, 0, 0, 29, 2, 0, 0)));
        dir_tab.push_back(cmd_row(CMD_SET_TIME, 23, 59, 59, 0, 0, 0));
        dir_tab.push_back(cmd_row(CMD_TICK, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(cmd_row(CMD_SET_DATE, 0, 0, 0, 28, 2, 2100));
        dir_tab.push_back(cmd_row(CMD_SET_TIME, 23, 59, 59, 0, 0, 0));
        dir_tab.push_back(cmd_row(CMD_TICK, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(cmd_row(CMD_SET_DATE, 0, 0, 0, 29, 2, 2000));
        dir_tab.push_back(cmd_row(CMD_SET_TIME, 23, 59, 59, 0, 0, 0));
        dir_tab.push_back(cmd_row(CMD_TICK, 0, 0, 0, 0, 0, 0));
        foreach (dir_tab[i])
            add_row(dir_tab[i]);

        // wait until the queue and the pipe are empty, then go random
        wait_drained();
        queue_random_mix(320);
        wait_drained();
        queue_random_mix(330);
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("covered %0d commands: %0d dates rejected, %0d midnight rollovers",
                 cmds_taken, rejects_seen, day_rolls);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", errors);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("timeout with %0d results outstanding", due_readings.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
